>>> rtl/glyph_texture_gutter_repack_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the glyph texture gutter repack core
// Wrap concurrent assertions clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXTURE_GUTTER_REPACK_CORE_MACROS_SVH
`define GLYPH_TEXTURE_GUTTER_REPACK_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define GTGR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define GTGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gtgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtgr_pkg
// Shared widths, register codes and the divider payload type.
// ----------------------------------------------------------------------------
package gtgr_pkg;

    localparam int MAX_SIDE_LOG2 = 9;
    localparam int SIDE_W        = 4;                    // log2 side registers
    localparam int COORD_W       = MAX_SIDE_LOG2;        // x / y coordinates
    localparam int IDX_W         = 2 * MAX_SIDE_LOG2;    // source index
    localparam int ADDR_W        = IDX_W + 1;            // destination address
    localparam int TEXEL_W       = 16;
    localparam int GW_W          = MAX_SIDE_LOG2 + 1;    // glyph width
    localparam int DX_W          = MAX_SIDE_LOG2 + 1;    // placed column
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = GW_W;
    localparam int DIV_BITS      = 3;                    // quotient bits per stage
    localparam int DIV_STAGES    = (COORD_W + DIV_BITS - 1) / DIV_BITS;
    localparam int S_DATA_W      = ((IDX_W + TEXEL_W + 7) / 8) * 8;
    localparam int M_DATA_W      = ((ADDR_W + TEXEL_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        LAYOUT_RECT      = 2'd0,
        LAYOUT_TWIDDLED  = 2'd1,
        LAYOUT_RECT_TWID = 2'd2,
        LAYOUT_UNSUP     = 2'd3
    } layout_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH_LOG2  = 2'd0,
        CFG_HEIGHT_LOG2 = 2'd1,
        CFG_GLYPH_WIDTH = 2'd2,
        CFG_LAYOUT      = 2'd3
    } cfg_idx_t;

    // Column divide in flight: numerator bits are consumed from the top.
    typedef struct packed {
        logic [COORD_W-1:0] num;
        logic [GW_W-1:0]    rem;
        logic [COORD_W-1:0] quo;
        logic [COORD_W-1:0] y;
        logic [TEXEL_W-1:0] texel;
    } div_t;

endpackage

>>> rtl/gtgr_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtgr_div_stage
// One registered stage of the restoring column divide by glyph width.
// ----------------------------------------------------------------------------
module gtgr_div_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [gtgr_pkg::GW_W-1:0] glyph_width,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  gtgr_pkg::div_t            in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output gtgr_pkg::div_t            out_data
);
    import gtgr_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    div_t  data_reg;
    div_t  data_next;

    // Retire DIV_BITS quotient bits.
    always_comb
    begin
        logic [GW_W:0] trial;
        data_next = in_data;
        for (int b = 0; b < DIV_BITS; b++)
        begin
            trial = {data_next.rem, data_next.num[COORD_W-1]};
            data_next.num = {data_next.num[COORD_W-2:0], 1'b0};
            if (trial >= {1'b0, glyph_width})
            begin
                trial = trial - {1'b0, glyph_width};
                data_next.quo = {data_next.quo[COORD_W-2:0], 1'b1};
            end
            else
            begin
                data_next.quo = {data_next.quo[COORD_W-2:0], 1'b0};
            end
            data_next.rem = trial[GW_W-1:0];
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/glyph_texture_gutter_repack_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_texture_gutter_repack_core
// Places source font texels into a texture twice as wide, with a transparent
// gutter beside every glyph cell, and clears that gutter on the fly.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata (low bit first)               tlast
//  --------  ---------  ----------------------------------  ------------
//  s_axis    in         src_index[17:0], texel_in[15:0]     -
//  m_axis    out        dst_address[18:0], texel_out[15:0]  last_of_item
//  cfg       in         cfg_index picks register, cfg_wdata is the value
//
//  Pipeline: decode, three divide stages (3 quotient bits each), multiply,
//  output register; m_tvalid is driven from the output register.
//  A texel is taken every cycle while s_tready is high; each kept one gives a
//  texel and a gutter request, so m_axis sets the rate; dropped texels give none.
//  Reset clears every valid bit and loads the register defaults.
//  A stall on m_axis holds each stage in place; bubbles close up first.
//
module glyph_texture_gutter_repack_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [gtgr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gtgr_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // source texels
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [gtgr_pkg::S_DATA_W-1:0]         s_tdata,  // src_index, texel_in
    // destination writes
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [gtgr_pkg::M_DATA_W-1:0]         m_tdata,  // dst_address, texel_out
    output logic                                  m_tlast   // last_of_item
);
    import gtgr_pkg::*;

    `include "glyph_texture_gutter_repack_core_macros.svh"

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] width_log2_reg;
    logic [SIDE_W-1:0] height_log2_reg;
    logic [GW_W-1:0]   glyph_width_reg;
    layout_t           layout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_log2_reg  <= SIDE_W'(3);
            height_log2_reg <= SIDE_W'(3);
            glyph_width_reg <= GW_W'(8);
            layout_reg      <= LAYOUT_RECT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH_LOG2:  width_log2_reg  <= cfg_wdata[SIDE_W-1:0];
                CFG_HEIGHT_LOG2: height_log2_reg <= cfg_wdata[SIDE_W-1:0];
                CFG_GLYPH_WIDTH: glyph_width_reg <= cfg_wdata[GW_W-1:0];
                CFG_LAYOUT:      layout_reg      <= layout_t'(cfg_wdata[1:0]);
                default:         ;
            endcase
        end
    end

    // Saturate side sizes to the largest supported texture.
    logic [SIDE_W-1:0] wl;
    logic [SIDE_W-1:0] hl;
    logic [SIDE_W-1:0] tl;

    assign wl = (width_log2_reg  > SIDE_W'(MAX_SIDE_LOG2)) ? SIDE_W'(MAX_SIDE_LOG2)
                                                           : width_log2_reg;
    assign hl = (height_log2_reg > SIDE_W'(MAX_SIDE_LOG2)) ? SIDE_W'(MAX_SIDE_LOG2)
                                                           : height_log2_reg;
    assign tl = (wl < hl) ? wl : hl;   // side of one square Morton tile

    // ------------------------------------------------------------------
    // Stage A: split the index into x / y, drop ineligible texels
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]   src_index;
    logic [TEXEL_W-1:0] texel_in;
    logic [COORD_W-1:0] x_dec;
    logic [COORD_W-1:0] y_dec;
    logic               keep;

    assign src_index = s_tdata[IDX_W-1:0];
    assign texel_in  = s_tdata[IDX_W +: TEXEL_W];

    always_comb
    begin
        logic [COORD_W-1:0] xm;
        logic [COORD_W-1:0] ym;
        logic [IDX_W-1:0]   tile;
        logic [IDX_W-1:0]   rect_y;
        xm = '0;
        ym = '0;
        for (int b = 0; b < COORD_W; b++)
        begin
            if (SIDE_W'(b) < tl)
            begin
                ym[b] = src_index[2*b];
                xm[b] = src_index[2*b+1];
            end
        end
        tile   = src_index >> ({1'b0, tl} << 1);
        rect_y = src_index >> wl;

        if (layout_reg == LAYOUT_RECT)
        begin
            x_dec = src_index[COORD_W-1:0] & COORD_W'((COORD_W+1)'(1) << wl) - COORD_W'(1);
            y_dec = rect_y[COORD_W-1:0];
        end
        else if (wl > hl)
        begin
            // Tiles stack along x.
            x_dec = xm | (tile[COORD_W-1:0] << tl);
            y_dec = ym;
        end
        else
        begin
            // Tiles stack along y (no tiles beyond the first when square).
            x_dec = xm;
            y_dec = ym | (tile[COORD_W-1:0] << tl);
        end

        keep = (layout_reg != LAYOUT_UNSUP) && (glyph_width_reg != '0)
            && ((src_index >> ({1'b0, wl} + {1'b0, hl})) == '0);
    end

    logic  a_valid_reg;
    logic  a_valid_next;
    div_t  a_data_reg;
    div_t  a_data_next;
    logic  a_ready;

    assign a_data_next = '{num: x_dec, rem: '0, quo: '0, y: y_dec, texel: texel_in};
    assign s_tready    = !a_valid_reg || a_ready;
    assign a_valid_next = s_tready ? (s_tvalid && keep) : a_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            a_data_reg <= a_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Divide stages: quotient and remainder of x by glyph width
    // ------------------------------------------------------------------
    logic [DIV_STAGES:0] d_valid;
    logic [DIV_STAGES:0] d_ready;
    div_t                d_data [DIV_STAGES+1];

    assign d_valid[0] = a_valid_reg;
    assign d_data[0]  = a_data_reg;
    assign a_ready    = d_ready[0];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        gtgr_div_stage u_div (
            .clk         (clk),
            .rst_n       (rst_n),
            .glyph_width (glyph_width_reg),
            .in_valid    (d_valid[k]),
            .in_ready    (d_ready[k]),
            .in_data     (d_data[k]),
            .out_valid   (d_valid[k+1]),
            .out_ready   (d_ready[k+1]),
            .out_data    (d_data[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage E: placed column dx = 2 * G * quotient + remainder
    // ------------------------------------------------------------------
    div_t                dq;
    logic [ADDR_W-1:0]   prod;
    logic                e_valid_reg;
    logic                e_valid_next;
    logic [DX_W-1:0]     e_dx_reg;
    logic [DX_W-1:0]     e_dx_next;
    logic [COORD_W-1:0]  e_y_reg;
    logic [TEXEL_W-1:0]  e_texel_reg;
    logic                e_ready;
    logic                f_ready;

    assign dq        = d_data[DIV_STAGES];
    assign prod      = ADDR_W'(dq.quo) * ADDR_W'(glyph_width_reg);
    assign e_dx_next = DX_W'({prod, 1'b0} + (ADDR_W+1)'(dq.rem));

    assign e_ready              = !e_valid_reg || f_ready;
    assign d_ready[DIV_STAGES]  = e_ready;
    assign e_valid_next         = e_ready ? d_valid[DIV_STAGES] : e_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= e_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && d_valid[DIV_STAGES])
        begin
            e_dx_reg    <= e_dx_next;
            e_y_reg     <= dq.y;
            e_texel_reg <= dq.texel;
        end
    end

    // ------------------------------------------------------------------
    // Stage F: output register, texel request then gutter request
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]  row_base;
    logic [ADDR_W-1:0]  addr_next;
    logic [ADDR_W-1:0]  gutter_next;
    logic               f_valid_reg;
    logic               f_valid_next;
    logic               f_phase_reg;
    logic               f_phase_next;
    logic [ADDR_W-1:0]  f_addr_reg;
    logic [ADDR_W-1:0]  f_gutter_reg;
    logic [TEXEL_W-1:0] f_texel_reg;
    logic               f_load;

    assign row_base    = ADDR_W'(e_y_reg) << ({1'b0, wl} + 5'd1);
    assign addr_next   = row_base + ADDR_W'(e_dx_reg);
    assign gutter_next = addr_next + ADDR_W'(glyph_width_reg);

    // Free once the gutter request leaves.
    assign f_ready = !f_valid_reg || (m_tready && f_phase_reg);
    assign f_load  = f_ready && e_valid_reg;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        f_phase_next = f_phase_reg;
        if (f_load)
        begin
            f_valid_next = 1'b1;
            f_phase_next = 1'b0;
        end
        else if (f_valid_reg && m_tready)
        begin
            // Advance to the gutter, or drop the finished pair.
            f_valid_next = !f_phase_reg;
            f_phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            f_phase_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
            f_phase_reg <= f_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_load)
        begin
            f_addr_reg   <= addr_next;
            f_gutter_reg <= gutter_next;
            f_texel_reg  <= e_texel_reg;
        end
    end

    assign m_tvalid = f_valid_reg;
    assign m_tlast  = f_phase_reg;
    assign m_tdata  = M_DATA_W'({(f_phase_reg ? TEXEL_W'(0) : f_texel_reg),
                                 (f_phase_reg ? f_gutter_reg : f_addr_reg)});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GTGR_ASSERT_NEXT(a_gutter_follows, m_tvalid && m_tready && !m_tlast,
        m_tvalid && m_tlast, "gutter request did not follow texel request")
    `GTGR_ASSERT_IMPL(a_gutter_zero, m_tvalid && m_tlast,
        m_tdata[ADDR_W +: TEXEL_W] == '0, "gutter request carries nonzero texel")
    `GTGR_ASSERT_IMPL(a_stall_source, !s_tready,
        m_tvalid && !(m_tready && m_tlast), "input held off while output drains")

endmodule
